[design/iprf_pkg.sv]
// ----------------------------------------------------------------------------
// iprf_pkg
// Shared types and constants of the IPv4 port rule filter.
// ----------------------------------------------------------------------------
package iprf_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_RULE = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } t_state;

    // verdict causes
    localparam logic [2:0] CAUSE_TRUNC    = 3'd0;
    localparam logic [2:0] CAUSE_NOT_IPV4 = 3'd1;
    localparam logic [2:0] CAUSE_OTHER    = 3'd2;
    localparam logic [2:0] CAUSE_DROP     = 3'd3;
    localparam logic [2:0] CAUSE_ALLOW    = 3'd4;
    localparam logic [2:0] CAUSE_USER     = 3'd5;
    localparam logic [2:0] CAUSE_NO_MATCH = 3'd6;

    // rule actions
    localparam logic [1:0] ACT_DROP     = 2'd0;
    localparam logic [1:0] ACT_ALLOW    = 2'd1;
    localparam logic [1:0] ACT_USER     = 2'd2;
    localparam logic [1:0] ACT_USER_ALT = 2'd3;

    // counter indexes
    localparam logic [2:0] CNT_TOTAL = 3'd0;
    localparam logic [2:0] CNT_TCP   = 3'd1;
    localparam logic [2:0] CNT_UDP   = 3'd2;
    localparam logic [2:0] CNT_DROP  = 3'd3;
    localparam logic [2:0] CNT_ALLOW = 3'd4;
    localparam logic [2:0] CNT_USER  = 3'd5;
    localparam int         NUM_CNT   = 6;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // minimum frame lengths
    localparam logic [6:0] LEN_ETH = 7'd14;
    localparam logic [6:0] LEN_IP  = 7'd34;
    localparam logic [6:0] LEN_UDP = 7'd42;
    localparam logic [6:0] LEN_TCP = 7'd54;

    // header byte offsets
    localparam logic [5:0] POS_ETH_HI = 6'd12;
    localparam logic [5:0] POS_ETH_LO = 6'd13;
    localparam logic [5:0] POS_PROTO  = 6'd23;
    localparam logic [5:0] POS_DST0   = 6'd30;
    localparam logic [5:0] POS_DST1   = 6'd31;
    localparam logic [5:0] POS_DST2   = 6'd32;
    localparam logic [5:0] POS_DST3   = 6'd33;
    localparam logic [5:0] POS_PORT0  = 6'd36;
    localparam logic [5:0] POS_PORT1  = 6'd37;
    localparam logic [5:0] POS_MAX    = 6'd63;

    localparam int RULE_W = 58;

    typedef struct packed {
        logic cap;
        logic last;
        logic wr_rule;
        logic rd_cnt;
        logic check;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic hit;
        logic last_slot;
        logic out_busy;
    } t_dp_sts;

endpackage

[design/iprf_if.sv]
// ----------------------------------------------------------------------------
// iprf_if
// Input and result channels of the IPv4 port rule filter.
// ----------------------------------------------------------------------------
interface iprf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  slot_index;
    logic        slot_valid;
    logic [7:0]  match_protocol;
    logic [31:0] match_address;
    logic [15:0] match_port;
    logic [1:0]  rule_action;
    logic [2:0]  counter_select;

    modport source (output valid, command, data_byte, last_byte, slot_index, slot_valid,
                    match_protocol, match_address, match_port, rule_action,
                    counter_select, input ready);
    modport sink   (input valid, command, data_byte, last_byte, slot_index, slot_valid,
                    match_protocol, match_address, match_port, rule_action,
                    counter_select, output ready);
endinterface

interface iprf_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        drop_frame;
    logic [2:0]  verdict_cause;
    logic [5:0]  matched_slot;
    logic [63:0] counter_value;

    modport source (output valid, result_kind, drop_frame, verdict_cause, matched_slot,
                    counter_value, input ready);
    modport sink   (input valid, result_kind, drop_frame, verdict_cause, matched_slot,
                    counter_value, output ready);
endinterface

[design/iprf_ram.sv]
// ----------------------------------------------------------------------------
// iprf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/iprf_ctrl.sv]
// ----------------------------------------------------------------------------
// iprf_ctrl
// Sequencer: accepts words, runs the header checks and the rule scan.
// ----------------------------------------------------------------------------
module iprf_ctrl
    import iprf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic [1:0] i_command,
    input  logic      i_last_byte,
    input  t_dp_sts   i_sts,
    output logic      o_ready,
    output t_dp_cmd   o_cmd
);
    t_state r_state, n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_command == CMD_BYTE && i_last_byte) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.early ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.last_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE) && !i_sts.out_busy;
        accept  = i_valid && o_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cap     = accept && (i_command == CMD_BYTE);
                o_cmd.last    = i_last_byte;
                o_cmd.wr_rule = accept && (i_command == CMD_RULE);
                o_cmd.rd_cnt  = accept && (i_command == CMD_READ);
            end
            S_CHECK: o_cmd.check = 1'b1;
            S_SCAN:  o_cmd.scan  = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

[design/iprf_dp.sv]
// ----------------------------------------------------------------------------
// iprf_dp
// Datapath: header capture, rule table, rule compare, counters, result word.
// ----------------------------------------------------------------------------
module iprf_dp
    import iprf_pkg::*;
#(
    parameter int RULE_SLOTS = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_slot_index,
    input  logic        i_slot_valid,
    input  logic [7:0]  i_match_protocol,
    input  logic [31:0] i_match_address,
    input  logic [15:0] i_match_port,
    input  logic [1:0]  i_rule_action,
    input  logic [2:0]  i_counter_select,
    output t_dp_sts     o_sts,
    iprf_out_if.source  o_out
);
    localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    logic [5:0]  r_pos;
    logic [6:0]  r_len;
    logic [15:0] r_etype;
    logic [7:0]  r_proto;
    logic [31:0] r_dst;
    logic [15:0] r_port;

    logic [RULE_SLOTS-1:0] r_slot_vld;
    logic [IW-1:0]         r_idx;
    logic [63:0]           r_cnt [NUM_CNT];

    logic        r_out_valid;
    logic        r_kind;
    logic        r_drop;
    logic [2:0]  r_cause;
    logic [5:0]  r_slot;
    logic [63:0] r_value;

    logic              wr_ok;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    logic [RULE_W-1:0] rdata;
    logic [1:0]        rd_act;
    logic              hit;
    logic              last_slot;
    logic              early;
    logic              early_drop;
    logic [2:0]        early_cause;
    logic              is_tcp;
    logic              is_udp;
    logic              ld_early;
    logic              ld_scan;
    logic              verdict_done;
    logic [NUM_CNT-1:0] inc;

    // rule table
    assign wr_ok = i_cmd.wr_rule && (i_slot_index != '0) && (int'(i_slot_index) <= RULE_SLOTS);
    assign waddr = IW'(int'(i_slot_index) - 1);
    assign raddr = i_cmd.check ? '0 : (last_slot ? r_idx : r_idx + 1'b1);

    iprf_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (waddr),
        .i_wdata ({i_match_protocol, i_match_address, i_match_port, i_rule_action}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_act    = rdata[1:0];
    assign last_slot = (int'(r_idx) == RULE_SLOTS - 1);
    assign hit = i_cmd.scan && r_slot_vld[r_idx] && (rdata[57:50] == r_proto)
              && (rdata[49:18] == r_dst) && (rdata[17:2] == r_port);

    // header checks, in priority order
    always_comb begin
        is_tcp      = (r_proto == PROTO_TCP);
        is_udp      = (r_proto == PROTO_UDP);
        early       = 1'b1;
        early_drop  = 1'b1;
        early_cause = CAUSE_TRUNC;
        if (r_len < LEN_ETH) begin
            early_drop = 1'b1;
        end else if (r_etype != ETHERTYPE_IPV4) begin
            early_drop  = 1'b0;
            early_cause = CAUSE_NOT_IPV4;
        end else if (r_len < LEN_IP) begin
            early_drop = 1'b1;
        end else if (is_tcp) begin
            early = (r_len < LEN_TCP);
        end else if (is_udp) begin
            early = (r_len < LEN_UDP);
        end else begin
            early_drop  = 1'b0;
            early_cause = CAUSE_OTHER;
        end
    end

    assign ld_early     = i_cmd.check && early;
    assign ld_scan      = i_cmd.scan && (hit || last_slot);
    assign verdict_done = ld_early || ld_scan;

    always_comb begin
        inc            = '0;
        inc[CNT_TOTAL] = i_cmd.check;
        inc[CNT_TCP]   = i_cmd.check && !early && is_tcp;
        inc[CNT_UDP]   = i_cmd.check && !early && is_udp;
        inc[CNT_DROP]  = hit && (rd_act == ACT_DROP);
        inc[CNT_ALLOW] = hit && (rd_act == ACT_ALLOW);
        inc[CNT_USER]  = hit && rd_act[1];
    end

    assign o_sts.early     = early;
    assign o_sts.hit       = hit;
    assign o_sts.last_slot = last_slot;
    assign o_sts.out_busy  = r_out_valid && !o_out.ready;

    // frame capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_etype <= '0;
            r_proto <= '0;
            r_dst   <= '0;
            r_port  <= '0;
        end else if (i_cmd.cap) begin
            case (r_pos) inside
                POS_ETH_HI: r_etype[15:8] <= i_data_byte;
                POS_ETH_LO: r_etype[7:0]  <= i_data_byte;
                POS_PROTO:  r_proto       <= i_data_byte;
                POS_DST0, POS_DST1, POS_DST2, POS_DST3: r_dst <= {r_dst[23:0], i_data_byte};
                POS_PORT0, POS_PORT1: r_port <= {r_port[7:0], i_data_byte};
                default: ;
            endcase
            if (i_cmd.last) begin
                r_len <= {1'b0, r_pos} + 7'd1;
                r_pos <= '0;
            end else if (r_pos != POS_MAX) begin
                r_pos <= r_pos + 6'd1;
            end
        end else if (verdict_done) begin
            r_etype <= '0;
            r_proto <= '0;
            r_dst   <= '0;
            r_port  <= '0;
        end
    end

    // slot valid bits and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_idx      <= '0;
        end else begin
            if (wr_ok) begin
                r_slot_vld[waddr] <= i_slot_valid;
            end
            if (i_cmd.check) begin
                r_idx <= '0;
            end else if (i_cmd.scan && !hit && !last_slot) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // event counters, wrap at 2^64
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CNT; i++) begin
                if (inc[i]) begin
                    r_cnt[i] <= r_cnt[i] + 64'd1;
                end
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rd_cnt || verdict_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cnt) begin
            r_kind  <= 1'b1;
            r_drop  <= 1'b0;
            r_cause <= CAUSE_TRUNC;
            r_slot  <= '0;
            r_value <= (int'(i_counter_select) < NUM_CNT) ? r_cnt[i_counter_select] : '0;
        end else if (ld_early) begin
            r_kind  <= 1'b0;
            r_drop  <= early_drop;
            r_cause <= early_cause;
            r_slot  <= '0;
            r_value <= '0;
        end else if (ld_scan) begin
            r_kind  <= 1'b0;
            r_value <= '0;
            if (hit) begin
                r_drop  <= (rd_act == ACT_DROP);
                r_cause <= (rd_act == ACT_DROP) ? CAUSE_DROP
                         : ((rd_act == ACT_ALLOW) ? CAUSE_ALLOW : CAUSE_USER);
                r_slot  <= 6'(int'(r_idx) + 1);
            end else begin
                r_drop  <= 1'b0;
                r_cause <= CAUSE_NO_MATCH;
                r_slot  <= '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_kind;
    assign o_out.drop_frame    = r_drop;
    assign o_out.verdict_cause = r_cause;
    assign o_out.matched_slot  = r_slot;
    assign o_out.counter_value = r_value;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        verdict_done |-> !(r_out_valid && !o_out.ready))
        else $error("verdict loaded over an unconsumed result");

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        verdict_done |=> (r_pos == '0) && (r_proto == '0) && (r_dst == '0))
        else $error("frame state not cleared after verdict");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (int'(r_idx) < RULE_SLOTS))
        else $error("rule scan index out of range");
endmodule

[design/ipv4_port_rule_filter.sv]
// ----------------------------------------------------------------------------
// ipv4_port_rule_filter
// Exact-match IPv4 frame classifier with a rule table and event counters.
// ----------------------------------------------------------------------------
// The last byte of a frame starts the header checks, which either decide the
// verdict themselves or pass the frame to the rule stage: the rule table sits
// in a RAM with one read port, and the scan compares one slot per cycle,
// stopping at the first valid match. Input ready stays low during that scan
// and while a result waits to be taken.
// ----------------------------------------------------------------------------
module ipv4_port_rule_filter
    import iprf_pkg::*;
#(
    parameter int RULE_SLOTS = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iprf_in_if.sink     i_in,
    iprf_out_if.source  o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    iprf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_command   (i_in.command),
        .i_last_byte (i_in.last_byte),
        .i_sts       (sts),
        .o_ready     (i_in.ready),
        .o_cmd       (cmd)
    );

    iprf_dp #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_data_byte      (i_in.data_byte),
        .i_slot_index     (i_in.slot_index),
        .i_slot_valid     (i_in.slot_valid),
        .i_match_protocol (i_in.match_protocol),
        .i_match_address  (i_in.match_address),
        .i_match_port     (i_in.match_port),
        .i_rule_action    (i_in.rule_action),
        .i_counter_select (i_in.counter_select),
        .o_sts            (sts),
        .o_out            (o_out)
    );
endmodule
